// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the trained peak detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/tpd_pkg.sv =====
// Package with the types and constants of the trained peak detector.
`default_nettype none
package tpd_pkg;
	localparam int NumBins = 20;
	localparam int SW = 16;
	localparam int TW = 16;
	localparam int BinW = 5;
	localparam int IdxW = 5;

	typedef enum logic [1:0] {
		PH_PEAK   = 2'd0,
		PH_HEIGHT = 2'd1,
		PH_NOISE  = 2'd2,
		PH_DETECT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_PEAK  = 2'd2,
		EV_END   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		REG_TRAIN  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_NOISE  = 3'd2,
		REG_DETECT = 3'd3,
		REG_REFR   = 3'd4,
		REG_GUARD  = 3'd5,
		REG_GAP    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic          train_en;
		logic [TW-1:0] height_start;
		logic [TW-1:0] noise_start;
		logic [TW-1:0] detect_start;
		logic [TW-1:0] refr;
		logic [TW-1:0] guard;
		logic [TW-1:0] gap;
	} cfg_t;
endpackage
`default_nettype wire

// ===== hdl/tpd_regs.sv =====
// APB configuration registers of the trained peak detector.
`default_nettype none
module tpd_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output tpd_pkg::cfg_t    cfg
);
	tpd_pkg::cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.train_en     <= 1'b1;
			cfg_q.height_start <= 16'd5000;
			cfg_q.noise_start  <= 16'd10000;
			cfg_q.detect_start <= 16'd10001;
			cfg_q.refr         <= 16'd600;
			cfg_q.guard        <= 16'd80;
			cfg_q.gap          <= 16'd600;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				tpd_pkg::REG_TRAIN:  cfg_q.train_en     <= pwdata[0];
				tpd_pkg::REG_HEIGHT: cfg_q.height_start <= pwdata[15:0];
				tpd_pkg::REG_NOISE:  cfg_q.noise_start  <= pwdata[15:0];
				tpd_pkg::REG_DETECT: cfg_q.detect_start <= pwdata[15:0];
				tpd_pkg::REG_REFR:   cfg_q.refr         <= pwdata[15:0];
				tpd_pkg::REG_GUARD:  cfg_q.guard        <= pwdata[15:0];
				tpd_pkg::REG_GAP:    cfg_q.gap          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tpd_pkg::REG_TRAIN:  prdata = {31'd0, cfg_q.train_en};
			tpd_pkg::REG_HEIGHT: prdata = {16'd0, cfg_q.height_start};
			tpd_pkg::REG_NOISE:  prdata = {16'd0, cfg_q.noise_start};
			tpd_pkg::REG_DETECT: prdata = {16'd0, cfg_q.detect_start};
			tpd_pkg::REG_REFR:   prdata = {16'd0, cfg_q.refr};
			tpd_pkg::REG_GUARD:  prdata = {16'd0, cfg_q.guard};
			tpd_pkg::REG_GAP:    prdata = {16'd0, cfg_q.gap};
			default:             prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/trained_peak_detector.sv =====
// Top level of the trained peak detector: handshake, sequencer and the shared bin walk.
`default_nettype none
`include "assert_macros.svh"
// The trained peak detector takes one signed 16-bit sample per stream transaction and returns
// exactly one result transaction per sample. A wrapping tick counter selects the phase: peak
// learning, height histogram learning, noise learning and detection; with training disabled
// the block detects from the first sample. Samples in the peak and noise phases and in
// detection are worked on in the cycle after acceptance and then pass through the holding
// register to the output register. Height-learning samples walk the 21-entry histogram
// with one shared compare-and-increment unit, one bin per cycle, then walk the 20 bin pairs
// backward for the threshold choice, one pair per cycle, and finish the threshold in the
// execute state. A finished result waits in a holding register while the output register
// still holds an earlier transaction that has not been taken, and input is not ready while
// a sample is in work or its result waits there. The bin step (max/2 - max/4)/20 comes from
// a reciprocal multiplication, bin heights are built by repeated addition of the step
// through the walk, and the threshold sum is halved with a shift. Configuration writes go to
// registers through the APB port at byte addresses 4*i; they are meant to be written while
// the block is idle.
module trained_peak_detector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [1:0] phase, [3:2] event_res, [4] healthy,
	                                    // [5] health_changed, [21:6] threshold,
	                                    // [37:22] noise_level, [39:38] zero
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int NB = tpd_pkg::NumBins;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_HIST  = 5'b00100,
		ST_THR   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	tpd_pkg::cfg_t cfg;
	state_t state_q;

	tpd_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// Detector state.
	logic [15:0] tick_q, last_peak_q;
	logic        done_q, invert_q, falling_q, seek_pk_q, seek_end_q, healthy_q;
	logic signed [15:0] max_q, prev_q, upper_q, lower_q, thr_q, noise_q, s_q;
	tpd_pkg::phase_t phase_q;
	logic [15:0] hist_q [NB+1];

	// Walk state.
	logic [tpd_pkg::IdxW-1:0] k_q;
	logic signed [17:0] th_q;
	logic        hit_q, upfound_q, cnt_q;
	logic signed [15:0] step_q, up_new_q, lo_new_q;
	logic        lo_found_q;

	// Holding register and output register.
	logic [39:0] res_q;
	logic [39:0] out_q;
	logic        ovalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	// Input after inversion with saturation.
	logic signed [15:0] s_in, s_inv;
	assign s_in = s_tdata;
	assign s_inv = invert_q ? ((s_in == 16'sh8000) ? 16'sh7FFF : -s_in) : s_in;

	function automatic logic signed [15:0] mag(input logic signed [15:0] x);
		if (x == 16'sh8000) return 16'sh7FFF;
		return (x < 0) ? -x : x;
	endfunction

	// Phase selection with the old count.
	tpd_pkg::phase_t ph_next;
	logic            done_next;
	always_comb begin
		ph_next = phase_q;
		done_next = done_q;
		if (cfg.train_en && !done_q) begin
			if (tick_q == cfg.detect_start) begin
				ph_next = tpd_pkg::PH_DETECT; done_next = 1'b1;
			end else if (tick_q == cfg.noise_start) ph_next = tpd_pkg::PH_NOISE;
			else if (tick_q == cfg.height_start) ph_next = tpd_pkg::PH_HEIGHT;
			else if (tick_q == 16'd0) ph_next = tpd_pkg::PH_PEAK;
		end else begin
			ph_next = tpd_pkg::PH_DETECT;
		end
	end

	// Detection arithmetic on the registered sample.
	logic signed [15:0] a_s;
	logic [15:0] el0, el1, lp_new;
	logic        sp_n, se_n, h_n;
	tpd_pkg::event_t ev_n;
	assign a_s = mag(s_q);
	assign el0 = tick_q - last_peak_q;
	always_comb begin
		sp_n = seek_pk_q; se_n = seek_end_q; lp_new = last_peak_q; ev_n = tpd_pkg::EV_NONE;
		if (a_s < thr_q && a_s > noise_q && el0 > cfg.refr && !seek_end_q && !seek_pk_q) begin
			sp_n = 1'b1; ev_n = tpd_pkg::EV_START;
		end else if (s_q > thr_q && seek_pk_q && !seek_end_q) begin
			lp_new = tick_q; se_n = 1'b1; sp_n = 1'b0; ev_n = tpd_pkg::EV_PEAK;
		end else if (a_s < noise_q && el0 > cfg.guard && seek_end_q && !seek_pk_q) begin
			se_n = 1'b0; ev_n = tpd_pkg::EV_END;
		end
		el1 = tick_q - lp_new;
		h_n = el1 > cfg.gap;
	end

	// Height phase: bin quantities; lo and step from max.
	// The difference max/2 - max/4 never exceeds 8192, and multiplying by 3277 and
	// dropping 16 bits gives the exact floor of a division by 20 up to 16383.
	logic signed [15:0] lo_c, half_c;
	logic signed [15:0] step_c;
	logic [15:0] diff_c;
	logic [27:0] step_prod;
	assign lo_c = max_q >>> 2;
	assign half_c = max_q >>> 1;
	assign diff_c = 16'(half_c - lo_c);
	assign step_prod = 28'(diff_c) * 28'd3277;
	assign step_c = 16'(step_prod >> 16);

	// A falling edge after a peak above the lowest bin is counted into the histogram.
	logic hit_c;
	assign hit_c = (s_inv < prev_q) && (prev_q > lo_c) && !falling_q;

	logic [15:0] hk, hk1;
	assign hk  = hist_q[k_q];
	assign hk1 = hist_q[k_q + 5'd1];

	function automatic logic [39:0] pack(input tpd_pkg::phase_t p, input tpd_pkg::event_t e,
			input logic h, input logic c, input logic [15:0] t, input logic [15:0] n);
		return {2'b00, n, t, c, h, e, p};
	endfunction

	logic signed [16:0] sum_c;
	logic signed [15:0] up_f, lo_f;
	assign up_f = upfound_q ? up_new_q : upper_q;
	assign lo_f = lo_found_q ? lo_new_q : lower_q;
	assign sum_c = 17'(up_f) + 17'(lo_f);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; tick_q <= '0; last_peak_q <= '0; done_q <= 1'b0;
			invert_q <= 1'b0; falling_q <= 1'b0; seek_pk_q <= 1'b0; seek_end_q <= 1'b0;
			healthy_q <= 1'b1; max_q <= '0; prev_q <= '0; upper_q <= '0; lower_q <= '0;
			thr_q <= '0; noise_q <= '0; phase_q <= tpd_pkg::PH_PEAK; ovalid_q <= 1'b0;
			for (int i = 0; i <= NB; i++) hist_q[i] <= '0;
			k_q <= '0; hit_q <= 1'b0; upfound_q <= 1'b0; lo_found_q <= 1'b0; cnt_q <= 1'b0;
		end else begin
			// The output register takes the held result once it is free or being taken.
			if (state_q == ST_OUT && (!ovalid_q || m_tready)) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					phase_q <= ph_next; done_q <= done_next;
					tick_q <= tick_q + 16'd1;
					s_q <= s_inv;
					state_q <= (ph_next == tpd_pkg::PH_HEIGHT) ? ST_HIST : ST_EXEC;
					k_q <= '0; step_q <= step_c; th_q <= 18'(lo_c);
					cnt_q <= hit_c;
					hit_q <= hit_c;
				end
				ST_EXEC: begin
					if (phase_q == tpd_pkg::PH_PEAK) begin
						if (mag(s_q) > max_q) begin
							if (s_q < 0) invert_q <= 1'b1;
							max_q <= mag(s_q);
						end
						res_q <= pack(phase_q, tpd_pkg::EV_NONE, healthy_q, 1'b0, thr_q, noise_q);
					end else if (phase_q == tpd_pkg::PH_NOISE) begin
						if (s_q < lower_q && s_q > noise_q) noise_q <= s_q;
						res_q <= pack(phase_q, tpd_pkg::EV_NONE, healthy_q, 1'b0, thr_q,
							(s_q < lower_q && s_q > noise_q) ? s_q : noise_q);
					end else if (phase_q == tpd_pkg::PH_HEIGHT) begin
						// Finish the threshold after the last pair was examined.
						upper_q <= up_f;
						lower_q <= (upfound_q && lo_found_q) ? lo_new_q : lower_q;
						thr_q <= (sum_c > 0) ? 16'(sum_c >>> 1) : 16'sd0;
						res_q <= pack(phase_q, tpd_pkg::EV_NONE, healthy_q, 1'b0,
							(sum_c > 0) ? 16'(sum_c >>> 1) : 16'sd0, noise_q);
					end else begin
						seek_pk_q <= sp_n; seek_end_q <= se_n; last_peak_q <= lp_new;
						healthy_q <= h_n;
						res_q <= pack(phase_q, ev_n, h_n, h_n != healthy_q, thr_q, noise_q);
					end
					state_q <= ST_OUT;
				end
				ST_HIST: begin
					// One bin per cycle; for a counted hit bin 0 counts always, bin k if prev > lo + k*step.
					if (cnt_q) begin
						if ((k_q == '0 || 18'(prev_q) > th_q) && hist_q[k_q] != 16'hFFFF)
							hist_q[k_q] <= hist_q[k_q] + 16'd1;
						if (k_q != '0 && !(18'(prev_q) > th_q)) cnt_q <= 1'b0;
					end
					if (k_q == 5'(NB)) begin
						// th_q already holds lo + NB*step, the height of the top pair.
						if (hit_q) falling_q <= 1'b1;
						else if (falling_q && s_q > prev_q) falling_q <= 1'b0;
						prev_q <= s_q;
						k_q <= 5'(NB - 1);
						hit_q <= 1'b0; upfound_q <= 1'b0; lo_found_q <= 1'b0;
						state_q <= ST_THR;
					end else begin
						th_q <= th_q + 18'(step_q);
						k_q <= k_q + 5'd1;
					end
				end
				ST_THR: begin
					// Backward walk over bin pairs; th_q holds the height of pair k.
					if (!upfound_q) begin
						if (hk == hk1) begin
							upfound_q <= 1'b1; up_new_q <= 16'(th_q);
						end
					end else if (!lo_found_q) begin
						if (hk != hk1) begin
							lo_found_q <= 1'b1; lo_new_q <= 16'(th_q);
						end
					end
					th_q <= th_q - 18'(step_q);
					if (k_q == '0) state_q <= ST_EXEC;
					else k_q <= k_q - 5'd1;
				end
				ST_OUT: begin
					if (!ovalid_q || m_tready) begin
						out_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Lower height only changes when an upper one was found.
	logic lo_valid;
	assign lo_valid = upfound_q && lo_found_q;

	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_IMPLY(a_seek_excl, clk, arst_n, 1'b1, !(seek_pk_q && seek_end_q))
	`ASSERT_IMPLY(a_lo_needs_up, clk, arst_n, lo_valid, upfound_q)
endmodule
`default_nettype wire
